// ----- src/dtti_pkg.sv -----
// ----------------------------------------------------------------------------
// dtti_pkg
// Types and constants shared by the decimal text to integer converter.
// ----------------------------------------------------------------------------
package dtti_pkg;

	// saturation limits
	localparam logic [63:0] MAG_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// unsigned maximums
	localparam logic [63:0] U16_MAX = 64'd65535;
	localparam logic [63:0] U32_MAX = 64'd4294967295;

	// signed maximums and magnitudes of the minimums
	localparam logic [63:0] I16_MAX = 64'd32767;
	localparam logic [63:0] I32_MAX = 64'd2147483647;
	localparam logic [63:0] I64_MAX = 64'd9223372036854775807;
	localparam logic [63:0] I16_ABSMIN = 64'd32768;
	localparam logic [63:0] I32_ABSMIN = 64'd2147483648;
	localparam logic [63:0] I64_ABSMIN = 64'h8000_0000_0000_0000;

	// result type codes
	localparam logic [2:0] RT_U16 = 3'd0;
	localparam logic [2:0] RT_U32 = 3'd1;
	localparam logic [2:0] RT_U64 = 3'd2;
	localparam logic [2:0] RT_I16 = 3'd3;
	localparam logic [2:0] RT_I32 = 3'd4;
	localparam logic [2:0] RT_I64 = 3'd5;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	// parser phase
	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_STOP   = 2'd3
	} phase_t;

	// input transaction
	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} dtti_in_t;

	// output transaction
	typedef struct packed {
		logic [63:0] value;
		logic        parsed;
		logic [15:0] consumed_count;
	} dtti_out_t;

	// end-of-string snapshot handed from parser to clamp stage
	typedef struct packed {
		logic [63:0] magnitude;
		logic        negative;
		logic [15:0] end_count;
	} dtti_snap_t;

endpackage

// ----- src/dtti_parse.sv -----
// ----------------------------------------------------------------------------
// dtti_parse
// Input register, per-character parser state and end-of-string snapshot.
// ----------------------------------------------------------------------------
module dtti_parse
	import dtti_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dtti_in_t   in_data,
	output logic       snap_valid,
	input  logic       snap_ready,
	output dtti_snap_t snap_data
);

	logic        valid_s1;
	dtti_in_t    data_s1;
	logic        adv_s1;
	logic        snap_free;

	phase_t      phase_q;
	logic        negative_q;
	logic [63:0] magnitude_q;
	logic [15:0] position_q;
	logic [15:0] end_q;

	phase_t      phase_n;
	logic        negative_n;
	logic [63:0] magnitude_n;
	logic [15:0] position_n;
	logic [15:0] end_n;

	logic        is_digit;
	logic        is_space;
	logic [3:0]  digit;
	logic [15:0] position_inc;
	logic [67:0] mul10;
	logic [63:0] acc;

	logic        valid_s2;
	dtti_snap_t  snap_s2;

	// handshake: the snapshot slot frees when the clamp stage takes it
	assign snap_free = !valid_s2 || snap_ready;
	assign adv_s1    = valid_s1 && (!data_s1.last || snap_free);
	assign in_ready  = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// character classes
	assign is_digit = (data_s1.char_code >= CH_ZERO) && (data_s1.char_code <= CH_NINE);
	assign is_space = ((data_s1.char_code >= CH_TAB) && (data_s1.char_code <= CH_CR))
		|| (data_s1.char_code == CH_SPACE);
	assign digit    = data_s1.char_code[3:0];

	// saturating position count and decimal accumulate
	assign position_inc = (position_q == CNT_MAX) ? position_q : position_q + 16'd1;
	assign mul10 = ({4'b0000, magnitude_q} << 3) + ({4'b0000, magnitude_q} << 1)
		+ {64'd0, digit};
	assign acc   = (|mul10[67:64]) ? MAG_MAX : mul10[63:0];

	// next parser state
	always_comb begin
		phase_n     = phase_q;
		negative_n  = negative_q;
		magnitude_n = magnitude_q;
		position_n  = position_q;
		end_n       = end_q;
		unique case (phase_q)
			PH_SKIP: begin
				if (is_space) begin
					position_n = position_inc;
				end else if (data_s1.char_code == CH_PLUS) begin
					position_n = position_inc;
					phase_n    = PH_SIGN;
				end else if (data_s1.char_code == CH_MINUS) begin
					negative_n = 1'b1;
					position_n = position_inc;
					phase_n    = PH_SIGN;
				end else if (is_digit) begin
					magnitude_n = {60'd0, digit};
					phase_n     = PH_DIGITS;
					position_n  = position_inc;
					end_n       = position_inc;
				end else begin
					phase_n = PH_STOP;
				end
			end
			PH_SIGN, PH_DIGITS: begin
				if (is_digit) begin
					magnitude_n = (phase_q == PH_DIGITS) ? acc : {60'd0, digit};
					phase_n     = PH_DIGITS;
					position_n  = position_inc;
					end_n       = position_inc;
				end else begin
					phase_n = PH_STOP;
				end
			end
			default: begin
			end
		endcase
	end

	// parser state: cleared after the last character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			negative_q  <= 1'b0;
			magnitude_q <= 64'd0;
			position_q  <= 16'd0;
			end_q       <= 16'd0;
		end else if (adv_s1) begin
			if (data_s1.last) begin
				phase_q     <= PH_SKIP;
				negative_q  <= 1'b0;
				magnitude_q <= 64'd0;
				position_q  <= 16'd0;
				end_q       <= 16'd0;
			end else begin
				phase_q     <= phase_n;
				negative_q  <= negative_n;
				magnitude_q <= magnitude_n;
				position_q  <= position_n;
				end_q       <= end_n;
			end
		end
	end

	// end-of-string snapshot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (snap_free) begin
			valid_s2 <= adv_s1 && data_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && data_s1.last) begin
			snap_s2.magnitude <= magnitude_n;
			snap_s2.negative  <= negative_n;
			snap_s2.end_count <= end_n;
		end
	end

	assign snap_valid = valid_s2;
	assign snap_data  = snap_s2;

endmodule

// ----- src/dtti_clamp.sv -----
// ----------------------------------------------------------------------------
// dtti_clamp
// Clamps the final magnitude to the selected type into the output register.
// ----------------------------------------------------------------------------
module dtti_clamp
	import dtti_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] result_type,
	input  logic       snap_valid,
	output logic       snap_ready,
	input  dtti_snap_t snap_data,
	output logic       out_valid,
	input  logic       out_ready,
	output dtti_out_t  out_data
);

	logic        out_valid_q;
	dtti_out_t   out_q;
	logic [63:0] mag;
	logic        neg;
	logic [63:0] pos_max;
	logic [63:0] neg_absmin;
	logic [63:0] neg_mag;
	logic [63:0] clamped;
	logic        is_signed;

	assign mag = snap_data.magnitude;
	assign neg = snap_data.negative;

	// type limits
	always_comb begin
		is_signed  = 1'b1;
		pos_max    = I64_MAX;
		neg_absmin = I64_ABSMIN;
		unique case (result_type)
			RT_U16: begin
				is_signed = 1'b0;
				pos_max   = U16_MAX;
			end
			RT_U32: begin
				is_signed = 1'b0;
				pos_max   = U32_MAX;
			end
			RT_U64: begin
				is_signed = 1'b0;
				pos_max   = MAG_MAX;
			end
			RT_I16: begin
				pos_max    = I16_MAX;
				neg_absmin = I16_ABSMIN;
			end
			RT_I32: begin
				pos_max    = I32_MAX;
				neg_absmin = I32_ABSMIN;
			end
			default: begin
				pos_max    = I64_MAX;
				neg_absmin = I64_ABSMIN;
			end
		endcase
	end

	// clamp, negating for signed types with a minus sign
	assign neg_mag = (mag > neg_absmin) ? neg_absmin : mag;
	assign clamped = (is_signed && neg) ? (64'd0 - neg_mag)
		: ((mag > pos_max) ? pos_max : mag);

	// output register
	assign snap_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_ready) begin
			out_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			if (snap_data.end_count != 16'd0) begin
				out_q.value          <= clamped;
				out_q.parsed         <= 1'b1;
				out_q.consumed_count <= snap_data.end_count;
			end else begin
				out_q.value          <= 64'd0;
				out_q.parsed         <= 1'b0;
				out_q.consumed_count <= 16'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/decimal_text_to_integer.sv -----
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// Streams decimal text one character per transaction and returns the clamped
// integer, a parsed flag and the consumed character count per string.
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  in       in_valid / in_ready     in_data   (char_code, last)
//  out      out_valid / out_ready   out_data  (value, parsed, consumed_count)
//  cfg      cfg_wr_en               cfg_wr_data (result_type)
//
//  One character is taken every cycle unless a last character awaits a free
//  snapshot slot; the parser state register updates once per character
//  through a constant multiply-by-ten and add. From the input register a
//  result goes via the snapshot register, then the clamp/output register.
//  Reset sets result_type to i64 and clears the parser state.
//  When out_ready is low the output, snapshot and input registers fill in
//  turn; plain characters keep flowing until a last character must wait.
//
module decimal_text_to_integer
	import dtti_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dtti_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output dtti_out_t  out_data,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data
);

	logic [2:0] result_type_q;
	logic       snap_valid;
	logic       snap_ready;
	dtti_snap_t snap_data;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_type_q <= RT_I64;
		end else if (cfg_wr_en) begin
			result_type_q <= cfg_wr_data;
		end
	end

	// character parser
	dtti_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap_data  (snap_data)
	);

	// type clamp and output register
	dtti_clamp u_clamp (
		.clk         (clk),
		.arst_n      (arst_n),
		.result_type (result_type_q),
		.snap_valid  (snap_valid),
		.snap_ready  (snap_ready),
		.snap_data   (snap_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

// ----- tb/tb_decimal_text_to_integer.sv -----
// ----------------------------------------------------------------------------
// tb_decimal_text_to_integer
// Self-checking bench for the decimal text to integer converter: a directed
// table of short strings, then random strings under every result type.
// Every result transaction is checked field by field against the directed
// table's expected row or an in-bench parser model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_decimal_text_to_integer;
	import dtti_pkg::*;

	// clocking and idling knobs
	localparam int HALF_PERIOD = 2;
	localparam int IDLE_PCT    = 38;
	localparam int CALM_FROM   = 250;
	localparam int CALM_TO     = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 70;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      in_valid    = 1'b0;
	logic      in_ready;
	dtti_in_t  in_data     = '0;
	logic      out_valid;
	logic      out_ready   = 1'b0;
	dtti_out_t out_data;
	logic      cfg_wr_en   = 1'b0;
	logic [2:0] cfg_wr_data = RT_I64;

	decimal_text_to_integer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// bookkeeping
	int        error_count  = 0;
	int        sent_count   = 0;
	int        results_seen = 0;
	int        hold_left    = 0;
	dtti_out_t pending_results[$];
	logic [7:0] str_q[$];

	// parser model state
	phase_t      ps_phase = PH_SKIP;
	logic        ps_neg   = 1'b0;
	logic [63:0] ps_mag   = '0;
	logic [15:0] ps_pos   = '0;
	logic [15:0] ps_end   = '0;
	logic [2:0]  ps_type  = RT_I64;

	// directed stimulus rows
	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic        typed;
		logic [63:0] value;
		logic        parsed;
		logic [15:0] count;
	} dir_row_t;

	dir_row_t dir_tab [25] = '{
		// top and bottom character codes alone
		'{8'hFF,               1'b1, 1'b1, 64'd0, 1'b0, 16'd0},
		'{8'h00,               1'b1, 1'b1, 64'd0, 1'b0, 16'd0},
		// whitespace then a bare sign
		'{CH_SPACE,            1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_TAB,              1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_MINUS,            1'b1, 1'b1, 64'd0, 1'b0, 16'd0},
		// plus zero
		'{CH_PLUS,             1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_ZERO,             1'b1, 1'b1, 64'd0, 1'b1, 16'd2},
		// negative digit stopped by a letter, trailing digit ignored
		'{CH_CR,               1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_MINUS,            1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_ZERO + 8'd5,      1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{8'h78,               1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_ZERO + 8'd7,      1'b1, 1'b0, 64'd0, 1'b0, 16'd0},
		// minus zero
		'{CH_MINUS,            1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_ZERO,             1'b1, 1'b1, 64'd0, 1'b1, 16'd2},
		// top digit alone
		'{CH_NINE,             1'b1, 1'b1, 64'd9, 1'b1, 16'd1},
		// remaining whitespace codes
		'{8'h0A,               1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{8'h0B,               1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{8'h0C,               1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_ZERO + 8'd8,      1'b1, 1'b0, 64'd0, 1'b0, 16'd0},
		// a digit then the code just above the digit range, then the code below it alone
		'{CH_ZERO + 8'd4,      1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_NINE + 8'd1,      1'b1, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_ZERO - 8'd1,      1'b1, 1'b1, 64'd0, 1'b0, 16'd0},
		// second sign stops the conversion
		'{CH_PLUS,             1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_PLUS,             1'b0, 1'b0, 64'd0, 1'b0, 16'd0},
		'{CH_ZERO + 8'd1,      1'b1, 1'b1, 64'd0, 1'b0, 16'd0}
	};

	// magnitudes around every clamping boundary
	logic [63:0] limit_tab [14] = '{
		I16_MAX, I16_ABSMIN, I16_ABSMIN + 64'd1, U16_MAX, U16_MAX + 64'd1,
		I32_MAX, I32_ABSMIN, I32_ABSMIN + 64'd1, U32_MAX, U32_MAX + 64'd1,
		I64_MAX, I64_ABSMIN, I64_ABSMIN + 64'd1, MAG_MAX
	};

	// mismatch report
	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// parser model
	task automatic clear_parser();
		ps_phase = PH_SKIP;
		ps_neg   = 1'b0;
		ps_mag   = '0;
		ps_pos   = '0;
		ps_end   = '0;
	endtask

	task automatic bump_pos();
		if (ps_pos != CNT_MAX) begin
			ps_pos = ps_pos + 16'd1;
		end
	endtask

	task automatic take_digit(input logic [63:0] d);
		if (ps_phase != PH_DIGITS) begin
			ps_mag = d;
		end else if (ps_mag > (MAG_MAX - d) / 64'd10) begin
			ps_mag = MAG_MAX;
		end else begin
			ps_mag = ps_mag * 64'd10 + d;
		end
		ps_phase = PH_DIGITS;
		bump_pos();
		ps_end = ps_pos;
	endtask

	function automatic logic [63:0] clamp_value(input logic [63:0] mag, input logic neg,
			input logic [2:0] rt);
		logic [63:0] pos_lim;
		logic [63:0] neg_lim;
		case (rt)
			RT_U16: return (mag > U16_MAX) ? U16_MAX : mag;
			RT_U32: return (mag > U32_MAX) ? U32_MAX : mag;
			RT_U64: return mag;
			RT_I16: begin
				pos_lim = I16_MAX;
				neg_lim = I16_ABSMIN;
			end
			RT_I32: begin
				pos_lim = I32_MAX;
				neg_lim = I32_ABSMIN;
			end
			default: begin
				pos_lim = I64_MAX;
				neg_lim = I64_ABSMIN;
			end
		endcase
		if (!neg) begin
			return (mag > pos_lim) ? pos_lim : mag;
		end
		return 64'd0 - ((mag > neg_lim) ? neg_lim : mag);
	endfunction

	task automatic parse_char(input dtti_in_t it, output bit got, output dtti_out_t res);
		logic [7:0]  dv;
		logic [63:0] d;
		bit          is_digit;
		bit          is_space;
		dv       = it.char_code - CH_ZERO;
		d        = {56'd0, dv};
		is_digit = (it.char_code >= CH_ZERO) && (it.char_code <= CH_NINE);
		is_space = ((it.char_code >= CH_TAB) && (it.char_code <= CH_CR)) ||
			(it.char_code == CH_SPACE);
		case (ps_phase)
			PH_SKIP: begin
				if (is_space) begin
					bump_pos();
				end else if (it.char_code == CH_PLUS) begin
					bump_pos();
					ps_phase = PH_SIGN;
				end else if (it.char_code == CH_MINUS) begin
					ps_neg = 1'b1;
					bump_pos();
					ps_phase = PH_SIGN;
				end else if (is_digit) begin
					take_digit(d);
				end else begin
					ps_phase = PH_STOP;
				end
			end
			PH_SIGN, PH_DIGITS: begin
				if (is_digit) begin
					take_digit(d);
				end else begin
					ps_phase = PH_STOP;
				end
			end
			default: ;
		endcase
		got = it.last;
		res = '0;
		if (it.last) begin
			if (ps_end != 16'd0) begin
				res.value          = clamp_value(ps_mag, ps_neg, ps_type);
				res.parsed         = 1'b1;
				res.consumed_count = ps_end;
			end
			clear_parser();
		end
	endtask

	// input side: random gaps, then hold the transaction until accepted
	task automatic send_char(input dtti_in_t it, input bit typed, input dtti_out_t want);
		bit        got;
		dtti_out_t res;
		while (!(sent_count >= CALM_FROM && sent_count < CALM_TO) &&
				$urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
		parse_char(it, got, res);
		if (got) begin
			pending_results.push_back(typed ? want : res);
		end
	endtask

	task automatic send_string();
		dtti_in_t  it;
		dtti_out_t none;
		none = '0;
		foreach (str_q[i]) begin
			it.char_code = str_q[i];
			it.last      = (i == str_q.size() - 1);
			send_char(it, 1'b0, none);
		end
		str_q.delete();
	endtask

	// config write only once every result is out and the pipe has drained
	task automatic set_result_type(input logic [2:0] rt);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ps_type = rt;
	endtask

	// string builders
	function automatic logic [7:0] space_char();
		int k;
		k = $urandom_range(5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	task automatic append_decimal(input logic [63:0] v);
		logic [7:0]  digs[$];
		logic [63:0] r;
		do begin
			r = v % 64'd10;
			digs.push_front(CH_ZERO + r[7:0]);
			v = v / 64'd10;
		end while (v != 64'd0);
		foreach (digs[i]) str_q.push_back(digs[i]);
	endtask

	task automatic build_noise();
		int n;
		int r;
		n = $urandom_range(6, 1);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 30) begin
				str_q.push_back(CH_ZERO + 8'($urandom_range(9)));
			end else if (r < 45) begin
				str_q.push_back(space_char());
			end else if (r < 55) begin
				str_q.push_back(($urandom_range(1) == 1) ? CH_MINUS : CH_PLUS);
			end else begin
				str_q.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	// optional whitespace, sign and leading zeros, digits, optional junk tail
	task automatic build_number();
		int          k;
		int          n;
		logic [63:0] mag;
		n = $urandom_range(3);
		repeat (n) str_q.push_back(space_char());
		k = $urandom_range(2);
		if (k == 1) str_q.push_back(CH_PLUS);
		if (k == 2) str_q.push_back(CH_MINUS);
		n = ($urandom_range(7) == 0) ? $urandom_range(6, 1) : 0;
		repeat (n) str_q.push_back(CH_ZERO);
		case ($urandom_range(3))
			0: append_decimal(64'($urandom_range(999)));
			1: begin
				mag = {$urandom, $urandom};
				append_decimal(mag >> $urandom_range(63));
			end
			2: begin
				k = $urandom_range(14);
				if (k == 14) begin
					// one past the largest magnitude
					append_decimal(MAG_MAX);
					str_q[str_q.size() - 1] = str_q[str_q.size() - 1] + 8'd1;
				end else begin
					append_decimal(limit_tab[k]);
				end
			end
			default: begin
				// twenty digits or more, mostly past saturation
				n = $urandom_range(25, 20);
				str_q.push_back(CH_ZERO + 8'($urandom_range(9, 1)));
				repeat (n - 1) str_q.push_back(CH_ZERO + 8'($urandom_range(9)));
			end
		endcase
		if ($urandom_range(3) == 0) begin
			build_noise();
		end
	endtask

	task automatic random_phase(input logic [2:0] rt);
		int start;
		set_result_type(rt);
		start = sent_count;
		while (sent_count - start < PHASE_ITEMS) begin
			if ($urandom_range(99) < 70) begin
				build_number();
			end else begin
				build_noise();
			end
			send_string();
		end
	endtask

	// output side: check each result transaction, then pick next ready
	always @(posedge clk) begin
		dtti_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result value", out_data.value, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.value !== want.value)
					flag_mismatch("value", out_data.value, want.value);
				if (out_data.parsed !== want.parsed)
					flag_mismatch("parsed", 64'(out_data.parsed), 64'(want.parsed));
				if (out_data.consumed_count !== want.consumed_count)
					flag_mismatch("consumed_count", 64'(out_data.consumed_count),
						64'(want.consumed_count));
			end
			results_seen++;
			if (results_seen == 30 || results_seen == 60) begin
				hold_left = HOLD_CYCLES;
			end
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (results_seen >= 35 && results_seen < 50) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// main sequence
	initial begin
		dtti_in_t  it;
		dtti_out_t want;
		int        drain;
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed table under the reset type
		foreach (dir_tab[i]) begin
			it.char_code        = dir_tab[i].ch;
			it.last             = dir_tab[i].last;
			want.value          = dir_tab[i].value;
			want.parsed         = dir_tab[i].parsed;
			want.consumed_count = dir_tab[i].count;
			send_char(it, dir_tab[i].typed, want);
		end

		// random strings under every type code, unused codes included
		for (int rt = 0; rt < 8; rt++) begin
			random_phase(3'(rt));
		end
		in_valid <= 1'b0;

		// drain
		drain = 0;
		while (pending_results.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			flag_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);
		end

		$display("run covered %0d characters and %0d strings over result type codes 0 to 7,",
			sent_count, results_seen);
		$display("with random idling on both sides and long output stalls backing up the input");
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("timeout waiting for the converter");
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- decimal_text_to_integer.f -----
src/dtti_pkg.sv
src/dtti_parse.sv
src/dtti_clamp.sv
src/decimal_text_to_integer.sv
tb/tb_decimal_text_to_integer.sv
